// ===== rtl/pan_pkg.sv =====
// pan_pkg: constants shared by the peak amplitude normalizer
// no dependencies; used by peak_amplitude_normalizer_core
package pan_pkg;

  localparam int SAMPLE_W  = 16;               // sample and result width
  localparam int LOW_W     = 17;               // running minimum width
  localparam int NUM_W     = 30;               // |x|*32767 < 2^30
  localparam int DIGIT_W   = 2;                // radix-4 divider digit
  localparam int DIV_STEPS = NUM_W / DIGIT_W;  // digits per quotient
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PREM_W    = SAMPLE_W + DIGIT_W;

  localparam logic [LOW_W-1:0]    LOW_RESET = 17'h10000;
  localparam logic [7:0]          MID_8     = 8'd128;
  localparam logic [LOW_W:0]      MID_8_X   = 18'sd128;
  localparam logic [LOW_W:0]      TOP_8_X   = 18'sd127;

  // sample_mode codes
  localparam logic MODE_U8  = 1'b0;
  localparam logic MODE_S16 = 1'b1;

  // cmd codes
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SCALE   = 1'b1;

endpackage

// ===== rtl/peak_amplitude_normalizer_core.sv =====
// peak_amplitude_normalizer_core: two-pass peak normalizer with a radix-4 serial divider
// depends on pan_pkg for widths, constants and command codes
//
// usage
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes sample_mode: 0 unsigned 8-bit,
//   1 signed 16-bit; cfg_ready is always high, write only while the block is idle
//   s_axis word: tdata = sample_bits, tuser = cmd
//     cmd 0 measures the sample (min/max tracking), no result word
//     cmd 1 returns the scaled sample on m_axis; the first cmd 0 after a cmd 1
//     restarts the measurement
//   m_axis word: tdata = scaled_bits, tuser = unity (clip was flat, sample unchanged)
// scale path
//   a measure word leaves the block idle for the next word; a scale word goes through
//   a divider that retires 2 quotient bits per cycle over a 30-bit dividend, then
//   waits for a free output register and loads it, which raises m_axis_tvalid; no new
//   word is taken until then; flat or undividable cases skip the divider
// reset
//   rst (synchronous, active high) sets sample_mode to 16-bit, clears the
//   measurement (min 65536, max 0) and empties the output register
// stall
//   the result sits in the output register until m_axis_tready; a new word is
//   taken meanwhile, and the divider holds its quotient until the register frees up
module peak_amplitude_normalizer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // sample_mode
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_bits
  input  logic        s_axis_tuser,   // [0] cmd
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] scaled_bits
  output logic        m_axis_tuser    // [0] unity
);

  localparam int SW = pan_pkg::SAMPLE_W;
  localparam int LW = pan_pkg::LOW_W;
  localparam int NW = pan_pkg::NUM_W;
  localparam int DW = pan_pkg::DIGIT_W;
  localparam int PW = pan_pkg::PREM_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t          state;
  logic            sample_mode;
  logic [LW-1:0]   low_seen;
  logic [SW-1:0]   high_seen;
  logic            scaling_phase;

  // per-word working registers
  logic            job_mode;
  logic            job_neg;
  logic            job_pass;       // result is the raw sample
  logic            job_unity;
  logic [SW-1:0]   job_raw;
  logic [SW-1:0]   divisor;
  logic [NW-1:0]   num;            // dividend, shifted out one digit a cycle
  logic [SW-1:0]   prem;           // partial remainder
  logic [SW-1:0]   quo;            // low quotient bits, shifted in one digit a cycle
  logic [pan_pkg::STEP_W-1:0] step;

  logic            in_fire;
  logic            out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // ---------------- measurement ----------------
  logic [SW-1:0]   abs16;
  logic [SW-1:0]   meas_v;
  logic [LW-1:0]   base_low;
  logic [SW-1:0]   base_high;

  always_comb begin
    abs16     = s_axis_tdata[SW-1] ? SW'(~s_axis_tdata + 16'd1) : s_axis_tdata;
    meas_v    = (sample_mode == pan_pkg::MODE_U8) ? {8'd0, s_axis_tdata[7:0]} : abs16;
    base_low  = scaling_phase ? pan_pkg::LOW_RESET : low_seen;
    base_high = scaling_phase ? '0 : high_seen;
  end

  // ---------------- scale setup ----------------
  logic signed [LW:0] a8, b8, d8;
  logic               div_ok;
  logic [SW-1:0]      div_val;
  logic [7:0]         mag8;
  logic [NW:0]        prod16;
  logic [NW-1:0]      num_val;
  logic               neg_val;

  always_comb begin
    // 8-bit mode divisor: max(128 - min, max - 127)
    a8 = $signed(pan_pkg::MID_8_X) - $signed({1'b0, low_seen});
    b8 = $signed({2'b00, high_seen}) - $signed(pan_pkg::TOP_8_X);
    d8 = (a8 >= b8) ? a8 : b8;
    if (sample_mode == pan_pkg::MODE_U8) begin
      div_ok  = (d8 > 0);
      div_val = d8[SW-1:0];
      neg_val = !s_axis_tdata[7];
      mag8    = s_axis_tdata[7] ? (s_axis_tdata[7:0] - pan_pkg::MID_8)
                                : (pan_pkg::MID_8 - s_axis_tdata[7:0]);
    end else begin
      div_ok  = (high_seen != '0);
      div_val = high_seen;
      neg_val = s_axis_tdata[SW-1];
      mag8    = '0;
    end
    // |x| * 32767 as (|x| << 15) - |x|
    prod16 = {abs16, 15'd0} - (NW+1)'(abs16);
    if (sample_mode == pan_pkg::MODE_U8) begin
      num_val = NW'({mag8, 7'd0});
    end else begin
      num_val = prod16[NW-1:0];
    end
  end

  // ---------------- radix-4 divider step ----------------
  logic [PW-1:0] trial, d1, d2, d3, sub;
  logic [DW-1:0] digit;

  always_comb begin
    trial = {prem, num[NW-1 -: DW]};
    d1    = PW'(divisor);
    d2    = PW'({divisor, 1'b0});
    d3    = d1 + d2;
    priority if (trial >= d3) begin
      digit = 2'd3;
      sub   = d3;
    end else if (trial >= d2) begin
      digit = 2'd2;
      sub   = d2;
    end else if (trial >= d1) begin
      digit = 2'd1;
      sub   = d1;
    end else begin
      digit = 2'd0;
      sub   = '0;
    end
  end

  // ---------------- result formatting ----------------
  logic [SW-1:0] qs;
  logic [SW-1:0] result;

  always_comb begin
    qs = job_neg ? SW'(~quo + 16'd1) : quo;
    if (job_pass) begin
      result = (job_mode == pan_pkg::MODE_U8) ? {8'd0, job_raw[7:0]} : job_raw;
    end else if (job_mode == pan_pkg::MODE_U8) begin
      result = {8'd0, qs[7:0] + pan_pkg::MID_8};
    end else begin
      result = qs;
    end
  end

  // ---------------- control and state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sample_mode   <= pan_pkg::MODE_S16;
      low_seen      <= pan_pkg::LOW_RESET;
      high_seen     <= '0;
      scaling_phase <= 1'b0;
      m_axis_tvalid <= 1'b0;
      step          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_mode <= cfg_data;
      end
      // load a new result or drop the one just taken
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == pan_pkg::CMD_MEASURE) begin
              scaling_phase <= 1'b0;
              high_seen     <= (meas_v > base_high) ? meas_v : base_high;
              low_seen      <= ({1'b0, meas_v} < base_low) ? {1'b0, meas_v} : base_low;
            end else begin
              scaling_phase <= 1'b1;
              step          <= '0;
              if ((low_seen == {1'b0, high_seen}) || !div_ok) begin
                state <= ST_DONE;
              end else begin
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == pan_pkg::STEP_W'(pan_pkg::DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire && s_axis_tuser == pan_pkg::CMD_SCALE) begin
      job_mode  <= sample_mode;
      job_neg   <= neg_val;
      job_unity <= (low_seen == {1'b0, high_seen});
      job_pass  <= (low_seen == {1'b0, high_seen}) || !div_ok;
      job_raw   <= s_axis_tdata;
      divisor   <= div_val;
      num       <= num_val;
      prem      <= '0;
      quo       <= '0;
    end else if (state == ST_DIV) begin
      num  <= {num[NW-DW-1:0], {DW{1'b0}}};
      prem <= SW'(trial - sub);
      quo  <= {quo[SW-DW-1:0], digit};
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= result;
      m_axis_tuser <= job_unity;
    end
  end

endmodule

// ===== tb/tb_peak_amplitude_normalizer_core.sv =====
// tb_peak_amplitude_normalizer_core: self-checking bench for the two-pass peak normalizer
// drives measure and scale words, predicts every scaled word and checks the output stream
// depends on pan_pkg and peak_amplitude_normalizer_core
module tb_peak_amplitude_normalizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake

  typedef struct packed {
    logic        cmd;
    logic [15:0] bits;
  } sample_word_t;

  typedef struct packed {
    logic [15:0] scaled;
    logic        unity;
  } scaled_word_t;

  // dut ports, every input known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample_bits
  logic        s_axis_tuser = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] scaled_bits
  logic        m_axis_tuser;        // [0] unity

  // stimulus and scoreboard state
  sample_word_t pending[$];         // words waiting for the driver
  scaled_word_t scaled_q[$];        // predicted output words, oldest first
  sample_word_t drive_word;
  int           words_queued = 0;
  int           words_taken = 0;
  int           mismatch_cnt = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;
  int           tx_idle_pct = 14;
  int           rx_idle_pct = 69;

  // predictor copy of the block state
  logic         mode_model;
  logic [16:0]  min_seen;
  logic [15:0]  max_seen;
  logic         rescaling;

  peak_amplitude_normalizer_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s at result %0d: got %h, expected %h",
             $realtime, what, results_seen, got, want);
    mismatch_cnt++;
  endtask

  // advance the normalizer state by one accepted word, queue the scaled word if any
  task automatic normalize_word(input logic cmd, input logic [15:0] bits);
    scaled_word_t res;
    longint x, lo, hi, a, b, dv, q;
    if (cmd == pan_pkg::CMD_MEASURE) begin
      // first measure after a scale pass opens a new clip
      if (rescaling) begin
        min_seen  = pan_pkg::LOW_RESET;
        max_seen  = '0;
        rescaling = 1'b0;
      end
      // 8-bit tracks raw bytes, 16-bit tracks magnitudes
      if (mode_model == pan_pkg::MODE_U8) begin
        x = bits[7:0];
      end else begin
        x = $signed(bits);
        if (x < 0) x = -x;
      end
      lo = min_seen;
      hi = max_seen;
      if (x > hi) max_seen = x[15:0];
      if (x < lo) min_seen = x[16:0];
    end else begin
      rescaling = 1'b1;
      lo = min_seen;
      hi = max_seen;
      res.unity = 1'b0;
      if (min_seen == {1'b0, max_seen}) begin
        // flat clip: sample comes back unchanged
        res.unity  = 1'b1;
        res.scaled = (mode_model == pan_pkg::MODE_U8) ? {8'h00, bits[7:0]} : bits;
      end else if (mode_model == pan_pkg::MODE_U8) begin
        x  = bits[7:0];
        a  = 128 - lo;
        b  = hi - 127;
        dv = (a >= b) ? a : b;
        if (dv <= 0) begin
          res.scaled = {8'h00, bits[7:0]};
        end else begin
          // signed longint division truncates toward zero, low byte wraps
          q = ((x - 128) * 128) / dv + 128;
          res.scaled = {8'h00, q[7:0]};
        end
      end else begin
        x = $signed(bits);
        if (hi <= 0) begin
          res.scaled = bits;
        end else begin
          q = (x * 32767) / hi;
          res.scaled = q[15:0];
        end
      end
      scaled_q.push_back(res);
    end
  endtask

  // input driver: next word from the pending queue, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drive_word = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drive_word.bits;
        s_axis_tuser  <= drive_word.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: check output words first, then predict from the accepted input word
  always @(posedge clk) begin
    scaled_word_t want;
    if (rst) begin
      mode_model = pan_pkg::MODE_S16;
      min_seen   = pan_pkg::LOW_RESET;
      max_seen   = '0;
      rescaling  = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (scaled_q.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata, 16'h0000);
        end else begin
          want = scaled_q.pop_front();
          if (m_axis_tdata !== want.scaled)
            report_mismatch("scaled_bits", m_axis_tdata, want.scaled);
          if (m_axis_tuser !== want.unity)
            report_mismatch("unity", {15'b0, m_axis_tuser}, {15'b0, want.unity});
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) mode_model = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        normalize_word(s_axis_tuser, s_axis_tdata);
        words_taken++;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic cmd, input logic [15:0] bits);
    sample_word_t w;
    w.cmd  = cmd;
    w.bits = bits;
    pending.push_back(w);
    words_queued++;
  endtask

  // block idle: every word taken, every result out, divider drained
  task automatic settle_block();
    while (words_taken != words_queued || scaled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // called just after a rising edge with the block idle
  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // sample around ctr within +/- spr; unused upper byte in 8-bit mode stays random
  function automatic logic [15:0] gen_sample(input logic m, input int ctr, input int spr);
    int v;
    logic [15:0] w;
    v = ctr + int'($urandom_range(0, 2 * spr)) - spr;
    w = 16'($urandom());
    if (m == pan_pkg::MODE_U8) begin
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      w[7:0] = v[7:0];
    end else begin
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      w = v[15:0];
    end
    return w;
  endfunction

  // one well-formed clip: a measure pass then a scale pass
  task automatic push_clip(input logic m);
    int shape, ctr, spr, n_meas, n_scale;
    shape   = $urandom_range(0, 9);
    n_meas  = $urandom_range(1, 10);
    n_scale = $urandom_range(1, 10);
    if (m == pan_pkg::MODE_U8) begin
      ctr = $urandom_range(0, 255);
      if (shape == 0)      spr = 0;
      else if (shape <= 3) spr = $urandom_range(1, 8);
      else if (shape <= 6) spr = $urandom_range(9, 60);
      else                 spr = 255;
    end else begin
      ctr = 0;
      if (shape == 0) begin
        ctr = int'($urandom_range(0, 65535)) - 32768;
        spr = 0;
      end else if (shape <= 3) begin
        spr = $urandom_range(1, 255);
      end else if (shape <= 6) begin
        spr = $urandom_range(256, 8191);
      end else begin
        spr = 32768;
      end
    end
    repeat (n_meas) queue_word(pan_pkg::CMD_MEASURE, gen_sample(m, ctr, spr));
    // occasional full-range sample in the scale pass
    repeat (n_scale)
      queue_word(pan_pkg::CMD_SCALE,
                 ($urandom_range(0, 9) == 0) ? 16'($urandom()) : gen_sample(m, ctr, spr));
  endtask

  initial begin
    int   rand_start, roll, n;
    logic seg_mode;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing measured yet, 8-bit: no usable divisor
    write_mode(pan_pkg::MODE_U8);
    queue_word(pan_pkg::CMD_SCALE, 16'h00FF);
    settle_block();

    // 16-bit: no divisor, full-scale extremes, flat clip, then a narrow clip
    write_mode(pan_pkg::MODE_S16);
    queue_word(pan_pkg::CMD_SCALE,   16'h1234);
    queue_word(pan_pkg::CMD_MEASURE, 16'h8000);
    queue_word(pan_pkg::CMD_MEASURE, 16'h7FFF);
    queue_word(pan_pkg::CMD_MEASURE, 16'hFFFF);
    queue_word(pan_pkg::CMD_SCALE,   16'h8000);
    queue_word(pan_pkg::CMD_SCALE,   16'h7FFF);
    queue_word(pan_pkg::CMD_SCALE,   16'hFFFF);
    queue_word(pan_pkg::CMD_MEASURE, 16'h0005);
    queue_word(pan_pkg::CMD_SCALE,   16'hABCD);
    queue_word(pan_pkg::CMD_MEASURE, 16'h0078);
    queue_word(pan_pkg::CMD_MEASURE, 16'h0082);
    settle_block();

    // mode change keeps the 16-bit clip: tiny 8-bit divisor, quotient wraps
    write_mode(pan_pkg::MODE_U8);
    queue_word(pan_pkg::CMD_SCALE,   16'h00FF);
    queue_word(pan_pkg::CMD_SCALE,   16'hFF00);
    queue_word(pan_pkg::CMD_MEASURE, 16'h0000);
    queue_word(pan_pkg::CMD_MEASURE, 16'h00FF);
    queue_word(pan_pkg::CMD_SCALE,   16'h0000);
    queue_word(pan_pkg::CMD_SCALE,   16'hFFFF);
    queue_word(pan_pkg::CMD_MEASURE, 16'h1280);
    queue_word(pan_pkg::CMD_SCALE,   16'h3456);
    queue_word(pan_pkg::CMD_MEASURE, 16'h0040);
    queue_word(pan_pkg::CMD_MEASURE, 16'h00C8);
    settle_block();

    // 16-bit scaling against a byte-sized peak wraps
    write_mode(pan_pkg::MODE_S16);
    queue_word(pan_pkg::CMD_SCALE, 16'h7FFF);
    queue_word(pan_pkg::CMD_SCALE, 16'h8001);
    settle_block();

    // random segments: mode write, then clips, stale scale passes or noise
    rand_start = words_queued;
    while (words_queued < rand_start + RANDOM_ITEMS) begin
      if (words_queued < rand_start + RANDOM_ITEMS / 3) begin
        tx_idle_pct = 14;
        rx_idle_pct = 69;
      end else if (words_queued < rand_start + 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      seg_mode = 1'($urandom_range(0, 1));
      write_mode(seg_mode);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // scale pass on whatever clip the previous segment left
        n = $urandom_range(2, 8);
        repeat (n) queue_word(pan_pkg::CMD_SCALE, 16'($urandom()));
      end else if (roll < 22) begin
        n = $urandom_range(4, 16);
        repeat (n) queue_word(1'($urandom_range(0, 1)), 16'($urandom()));
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) push_clip(seg_mode);
      end
      settle_block();
    end

    if (mismatch_cnt == 0 && scaled_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pan_pkg.sv
rtl/peak_amplitude_normalizer_core.sv
tb/tb_peak_amplitude_normalizer_core.sv
